### rtl/shamd_pkg.sv
`default_nettype none
package shamd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       step;
    } t_sched_ctl;

    typedef struct packed {
        logic load;
        logic round;
        logic fold;
        logic rotate;
        logic reinit;
    } t_core_ctl;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] a);
        return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] e);
        return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] y);
        return {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ {10'b0, y[31:10]};
    endfunction

endpackage
`default_nettype wire

### rtl/shamd_sched.sv
`default_nettype none
module shamd_sched (
    input  wire                    i_clk,
    input  shamd_pkg::t_sched_ctl  i_ctl,
    output logic [31:0]            o_w
);

    logic [31:0] r_w [16];
    logic [31:0] n_new;

    assign n_new = shamd_pkg::small_sigma1(r_w[14]) + r_w[9]
                 + shamd_pkg::small_sigma0(r_w[1]) + r_w[0];

    // Bytes enter at the low end, so the first byte of a block ends up in the top of word 0.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_ctl.byte_val};
        end else if (i_ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_new;
        end
    end

    assign o_w = r_w[0];

endmodule
`default_nettype wire

### rtl/shamd_round.sv
`default_nettype none
module shamd_round (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  shamd_pkg::t_core_ctl  i_ctl,
    input  wire  [31:0]           i_k,
    input  wire  [31:0]           i_w,
    output logic [31:0]           o_word
);

    logic [31:0] r_wv    [8];
    logic [31:0] r_chain [8];
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [31:0] n_ch;
    logic [31:0] n_mj;

    always_comb begin
        n_ch = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
        n_mj = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
        n_t1 = r_wv[7] + shamd_pkg::big_sigma1(r_wv[4]) + n_ch + i_k + i_w;
        n_t2 = shamd_pkg::big_sigma0(r_wv[0]) + n_mj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) begin
                r_wv[i] <= r_chain[i];
            end
        end else if (i_ctl.round) begin
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + n_t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= n_t1 + n_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reinit) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= shamd_pkg::INIT_HASH[i];
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_wv[i];
            end
        end else if (i_ctl.rotate) begin
            // advance the next digest word into slot 0
            for (int i = 0; i < 7; i++) begin
                r_chain[i] <= r_chain[i+1];
            end
            r_chain[7] <= r_chain[0];
        end
    end

    assign o_word = r_chain[0];

endmodule
`default_nettype wire

### rtl/sha256_message_digest.sv
`default_nettype none
// SHA-256 over a byte stream. Each request on the slave side carries one byte (tuser high)
// or, with tuser low and tlast high, just closes the message; tlast marks the final request
// of a message. Bytes are taken one per cycle while the input is ready. Every 64th byte starts
// the shared round unit, which runs the rounds and then folds into the chaining value, with
// the input not ready meanwhile. At the end the block pads in hardware one byte per cycle
// (0x80, zeros, 64-bit bit length) up to the block boundary, runs one more compression, or
// two when fewer than nine bytes remain in the block, then presents the eight digest words
// most significant first, word index in tuser and tlast on the eighth.
module sha256_message_digest (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tuser,   // [0] byte_present
    input  wire         i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] word_index
    output logic        o_m_tlast    // last_word
);

    shamd_pkg::t_state     r_state, n_state;
    shamd_pkg::t_sched_ctl s_sched;
    shamd_pkg::t_core_ctl  s_core;

    logic [60:0] r_count, n_count;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_widx, n_widx;
    logic        r_in_pad, n_in_pad;
    logic        r_mark, n_mark;
    logic        r_len_ok, n_len_ok;

    logic        s_in_acc;
    logic        s_out_acc;
    logic [63:0] s_bits;
    logic [7:0]  s_len_byte;
    logic [7:0]  s_pad_byte;
    logic [31:0] s_w;

    assign s_in_acc   = i_s_tvalid && o_s_tready;
    assign s_out_acc  = o_m_tvalid && i_m_tready;
    assign s_bits     = {r_count, 3'b000};
    assign s_len_byte = s_bits[{~r_pos[2:0], 3'b000} +: 8];

    always_comb begin
        if (r_mark) begin
            s_pad_byte = shamd_pkg::PAD_MARK;
        end else if (r_len_ok && (r_pos >= shamd_pkg::LEN_POS)) begin
            s_pad_byte = s_len_byte;
        end else begin
            s_pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shamd_pkg::ST_IDLE: begin
                if (s_in_acc) begin
                    if (i_s_tuser && (r_pos == shamd_pkg::LAST_POS)) begin
                        n_state = shamd_pkg::ST_COMP;
                    end else if (i_s_tlast) begin
                        n_state = shamd_pkg::ST_PAD;
                    end
                end
            end
            shamd_pkg::ST_COMP: begin
                if (r_round == shamd_pkg::LAST_RND) begin
                    n_state = shamd_pkg::ST_FOLD;
                end
            end
            shamd_pkg::ST_FOLD: begin
                if (!r_in_pad) begin
                    n_state = shamd_pkg::ST_IDLE;
                end else if (r_len_ok) begin
                    n_state = shamd_pkg::ST_OUT;
                end else begin
                    n_state = shamd_pkg::ST_PAD;
                end
            end
            shamd_pkg::ST_PAD: begin
                if (r_pos == shamd_pkg::LAST_POS) begin
                    n_state = shamd_pkg::ST_COMP;
                end
            end
            shamd_pkg::ST_OUT: begin
                if (s_out_acc && (r_widx == shamd_pkg::LAST_IDX)) begin
                    n_state = shamd_pkg::ST_IDLE;
                end
            end
            default: n_state = shamd_pkg::ST_IDLE;
        endcase
    end

    // outputs and control
    always_comb begin
        o_s_tready        = 1'b0;
        o_m_tvalid        = 1'b0;
        s_sched.shift_byte = 1'b0;
        s_sched.byte_val   = i_s_tdata;
        s_sched.step       = 1'b0;
        s_core.load       = 1'b0;
        s_core.round      = 1'b0;
        s_core.fold       = 1'b0;
        s_core.rotate     = 1'b0;
        s_core.reinit     = 1'b0;
        unique case (r_state)
            shamd_pkg::ST_IDLE: begin
                o_s_tready         = 1'b1;
                s_sched.shift_byte = s_in_acc && i_s_tuser;
                s_core.load        = s_in_acc && i_s_tuser && (r_pos == shamd_pkg::LAST_POS);
            end
            shamd_pkg::ST_COMP: begin
                s_sched.step = 1'b1;
                s_core.round = 1'b1;
            end
            shamd_pkg::ST_FOLD: begin
                s_core.fold = 1'b1;
            end
            shamd_pkg::ST_PAD: begin
                s_sched.shift_byte = 1'b1;
                s_sched.byte_val   = s_pad_byte;
                s_core.load        = (r_pos == shamd_pkg::LAST_POS);
            end
            shamd_pkg::ST_OUT: begin
                o_m_tvalid    = 1'b1;
                s_core.rotate = s_out_acc && (r_widx != shamd_pkg::LAST_IDX);
                s_core.reinit = s_out_acc && (r_widx == shamd_pkg::LAST_IDX);
            end
            default: begin
            end
        endcase
    end

    // counters and flags
    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_round  = r_round;
        n_widx   = r_widx;
        n_in_pad = r_in_pad;
        n_mark   = r_mark;
        n_len_ok = r_len_ok;
        case (r_state)
            shamd_pkg::ST_IDLE: begin
                if (s_in_acc) begin
                    if (i_s_tuser) begin
                        n_count = r_count + 61'd1;
                        n_pos   = r_pos + 6'd1;
                    end
                    if (i_s_tlast) begin
                        n_in_pad = 1'b1;
                        n_mark   = 1'b1;
                        n_len_ok = 1'b0;
                    end
                end
            end
            shamd_pkg::ST_COMP: begin
                n_round = r_round + 6'd1;
            end
            shamd_pkg::ST_FOLD: begin
                // a padding compression without the length means one more block follows
                if (r_in_pad && !r_len_ok) begin
                    n_len_ok = 1'b1;
                end
            end
            shamd_pkg::ST_PAD: begin
                n_pos = r_pos + 6'd1;
                if (r_mark) begin
                    n_mark   = 1'b0;
                    n_len_ok = (r_pos < shamd_pkg::LEN_POS);
                end
            end
            shamd_pkg::ST_OUT: begin
                if (s_out_acc) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == shamd_pkg::LAST_IDX) begin
                        n_count  = '0;
                        n_in_pad = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= shamd_pkg::ST_IDLE;
            r_count  <= '0;
            r_pos    <= '0;
            r_round  <= '0;
            r_widx   <= '0;
            r_in_pad <= 1'b0;
            r_mark   <= 1'b0;
            r_len_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_round  <= n_round;
            r_widx   <= n_widx;
            r_in_pad <= n_in_pad;
            r_mark   <= n_mark;
            r_len_ok <= n_len_ok;
        end
    end

    shamd_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (s_sched),
        .o_w   (s_w)
    );

    shamd_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_core),
        .i_k     (shamd_pkg::ROUND_K[r_round]),
        .i_w     (s_w),
        .o_word  (o_m_tdata)
    );

    assign o_m_tuser = r_widx;
    assign o_m_tlast = (r_widx == shamd_pkg::LAST_IDX);

endmodule
`default_nettype wire

### tb/sha256_message_digest_test.sv
`default_nettype none
module sha256_message_digest_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 260;
    localparam int TAIL_START  = 220;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LENGTH_SLOT = 56;
    localparam int BLOCK_BYTES = 64;

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [31:0]  blk [16];
        logic [60:0]  byte_count;
        t_digest_word words_due [$];
        int           mismatches;

        function new();
            for (int i = 0; i < 8; i++) chain[i] = H_START[i];
            for (int i = 0; i < 16; i++) blk[i] = '0;
            byte_count = '0;
            mismatches = 0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, ch, mj;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 16; i < 64; i++) begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int r = 0; r < 64; r++) begin
                s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
                ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
                t1 = v[7] + s1 + ch + K_ROUND[r] + w[r];
                s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
                mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + s0 + mj;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        // big-endian within the word; the first byte of a word clears it
        function void put_byte(int pos, logic [7:0] b);
            if (pos % 4 == 0) blk[pos / 4] = '0;
            blk[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
        endfunction

        function void close_message();
            logic [63:0]  bit_len;
            int           pos;
            t_digest_word due;
            bit_len = {byte_count, 3'b000};
            pos = byte_count[5:0];
            put_byte(pos, PAD_BYTE);
            pos = pos + 1;
            // no room left for the length: spill into one more block
            if (pos > LENGTH_SLOT) begin
                while (pos < BLOCK_BYTES) begin
                    put_byte(pos, 8'h00);
                    pos = pos + 1;
                end
                compress();
                pos = 0;
            end
            while (pos < LENGTH_SLOT) begin
                put_byte(pos, 8'h00);
                pos = pos + 1;
            end
            blk[14] = bit_len[63:32];
            blk[15] = bit_len[31:0];
            compress();
            for (int i = 0; i < 8; i++) begin
                due.word = chain[i];
                due.idx  = 3'(i);
                due.last = (i == 7);
                words_due.push_back(due);
            end
            for (int i = 0; i < 8; i++) chain[i] = H_START[i];
            byte_count = '0;
        endfunction

        function void note_request(logic [7:0] b, logic present, logic last);
            int pos;
            if (present) begin
                pos = byte_count[5:0];
                put_byte(pos, b);
                byte_count = byte_count + 61'd1;
                if (pos == BLOCK_BYTES - 1) compress();
            end
            if (last) close_message();
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
            t_digest_word due;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected digest word %h index %0d last %b",
                         $time, word, idx, last);
                mismatches++;
                return;
            end
            due = words_due.pop_front();
            if (word !== due.word) begin
                $display("%0t: digest word expected %h actual %h", $time, due.word, word);
                mismatches++;
            end
            if (idx !== due.idx) begin
                $display("%0t: word index expected %0d actual %0d", $time, due.idx, idx);
                mismatches++;
            end
            if (last !== due.last) begin
                $display("%0t: last word expected %b actual %b", $time, due.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    digest_scoreboard sb;
    int  cycle_count = 0;
    int  items_sent = 0;
    bit  sender_calm = 0;
    bit  sink_calm = 0;
    bit  hold_armed = 0;

    sha256_message_digest dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sha256_message_digest_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_word(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // digest side: random stalls, plus one long hold-off so the block backs up
    initial begin : digest_sink
        int stall;
        int hold_left;
        bit hold_done;
        stall = 0;
        hold_left = 0;
        hold_done = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else if (stall > 0) begin
                i_m_tready = 1'b0;
                stall--;
            end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
                i_m_tready = 1'b0;
                stall = $urandom_range(1, 19) - 1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_request(input logic [7:0] b, input logic present, input logic last);
        int gap;
        gap = 0;
        if (!sender_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tuser  = present;
        i_s_tlast  = last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(b, present, last);
        if (present || last) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit sep_close);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, !sep_close && i == len - 1);
        end
        if (sep_close || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin : stimulus
        int len;
        int pick;
        bit tail;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_s_tlast  = 1'b0;
        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message, single extreme bytes, an ignored item inside a message
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        send_request(PAD_BYTE, 1'b1, 1'b1);

        // hold the digest side while the next messages keep coming
        hold_armed <= 1'b1;
        send_message(3, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            tail = items_sent >= TAIL_START;
            sender_calm = tail || $urandom_range(0, 3) == 0;
            sink_calm <= tail || $urandom_range(0, 3) == 0;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                len = $urandom_range(0, 12);
            else if (pick < 7)
                len = $urandom_range(0, 1) ? $urandom_range(54, 57) : $urandom_range(62, 65);
            else if (pick < 9)
                len = $urandom_range(13, 70);
            else
                len = $urandom_range(100, 140);
            // trim the last message so the run ends near the item target
            if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
            send_message(len, $urandom_range(0, 3) == 0);
        end
        i_s_tvalid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("sha256_message_digest_test OK");
        else
            $display("sha256_message_digest_test NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/shamd_pkg.sv
rtl/shamd_sched.sv
rtl/shamd_round.sv
rtl/sha256_message_digest.sv
tb/sha256_message_digest_test.sv
